### src/bounded_unique_list_top_assert.svh
// Assertion macros for the bounded unique list block.
// Used by bounded_unique_list_top; needs a clock named clk and a reset named rst.
`ifndef BOUNDED_UNIQUE_LIST_TOP_ASSERT_SVH
`define BOUNDED_UNIQUE_LIST_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BUL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_unique_list: assertion failed");
// next-cycle implication
`define BUL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_unique_list: assertion failed");
`else
`define BUL_ASSERT_IMPL(label, ante, cons)
`define BUL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/bul_pkg.sv
// Shared types and constants of the bounded unique list block.
// No dependencies; used by bul_ctrl, bul_dpath and bounded_unique_list_top.
`timescale 1ns / 1ps

package bul_pkg;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;
  localparam int IN_W    = 40;  // cmd + key + position, padded to bytes
  localparam int OUT_W   = 40;  // ok + key_out + count, padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REM_KEY = 3'd1,
    CMD_REM_POS = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic start;   // set up the scan index
    logic check;   // evaluate the entry just read
    logic finish;  // apply the result and load the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t op;
    logic scan_end;
    logic hit;
    logic fill_zero;
    logic pos_ok;
    logic out_free;
  } dp_status_t;

endpackage

### src/bul_ctrl.sv
// Sequencer for the bounded unique list block.
// Depends on bul_pkg; drives the datapath command struct.
`timescale 1ns / 1ps

module bul_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  bul_pkg::dp_status_t stat,
  output bul_pkg::dp_cmd_t    cmd
);
  import bul_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (stat.op)
          CMD_INSERT, CMD_REM_KEY: state_next = ST_RD;
          CMD_REM_POS: state_next = stat.pos_ok ? ST_RD : ST_DONE;
          CMD_READ:    state_next = stat.fill_zero ? ST_DONE : ST_RD;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_RD: begin
        state_next = stat.scan_end ? ST_DONE : ST_CHK;
      end
      ST_CHK: begin
        priority if (stat.op == CMD_READ) begin
          state_next = ST_DONE;
        end else if (stat.op == CMD_INSERT && stat.hit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECIDE: begin
        unique case (stat.op)
          CMD_INSERT, CMD_REM_KEY: cmd.start = 1'b1;
          CMD_REM_POS: cmd.start = stat.pos_ok;
          CMD_READ:    cmd.start = !stat.fill_zero;
          default:     cmd.start = 1'b0;
        endcase
      end
      ST_RD: begin
        cmd = '0;
      end
      ST_CHK: begin
        cmd.check = (stat.op != CMD_READ);
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/bul_dpath.sv
// Datapath of the bounded unique list: entry memory, fill count, scan index
// and output register. Depends on bul_pkg; steered by bul_ctrl.
`timescale 1ns / 1ps

module bul_dpath #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bul_pkg::dp_cmd_t         cmd,
  output bul_pkg::dp_status_t      stat,
  input  logic [bul_pkg::IN_W-1:0] in_data,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [bul_pkg::OUT_W-1:0] m_tdata
);
  import bul_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > CNT_W) ? FW : CNT_W;
  localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic [SW-1:0]    mem [CAPACITY];
  logic [SW-1:0]    rd_data;
  cmd_t             op_q;
  logic [SW-1:0]    key_q;
  logic [POS_W-1:0] pos_q;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    idx;
  logic             found;
  logic             m_valid;
  logic [OUT_W-1:0] m_data;

  logic [CW-1:0]    fill_ext, pos_ext, clamp, fill_new_ext;
  logic [FW-1:0]    idx_start, fill_new;
  logic             ok_r;
  logic [KEY_W-1:0] kout_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SW-1:0]    wr_data;
  logic             full;

  assign fill_ext = CW'(fill);
  assign pos_ext  = CW'(pos_q);
  assign full     = (fill_ext >= CW'(CAPACITY));
  assign clamp    = (pos_ext >= fill_ext) ? (fill_ext - CW'(1)) : pos_ext;

  assign stat.op        = op_q;
  assign stat.hit       = (rd_data == key_q);
  assign stat.fill_zero = (fill == '0);
  assign stat.pos_ok    = (pos_ext < fill_ext);
  assign stat.scan_end  = (op_q != CMD_READ) && (idx >= fill);
  assign stat.out_free  = !m_valid || m_tready;

  always_comb begin
    priority if (op_q == CMD_REM_POS) begin
      idx_start = FW'(pos_ext + CW'(1));
    end else if (op_q == CMD_READ) begin
      idx_start = FW'(clamp);
    end else begin
      idx_start = '0;
    end
  end

  // result of the operation, applied on finish
  always_comb begin
    ok_r     = 1'b0;
    kout_r   = '0;
    fill_new = fill;
    unique case (op_q)
      CMD_INSERT: begin
        ok_r = !found && !full;
        if (ok_r) fill_new = fill + FW'(1);
      end
      CMD_REM_KEY: begin
        ok_r = found;
        if (ok_r) fill_new = fill - FW'(1);
      end
      CMD_REM_POS: begin
        ok_r = stat.pos_ok;
        if (ok_r) fill_new = fill - FW'(1);
      end
      CMD_READ: begin
        ok_r = !stat.fill_zero;
        if (ok_r) kout_r = KEY_W'(rd_data);
      end
      CMD_CLEAR: begin
        ok_r     = 1'b1;
        fill_new = '0;
      end
      default: ok_r = 1'b0;
    endcase
  end

  assign fill_new_ext = CW'(fill_new);

  // single write port: compaction shift during the scan, append on finish
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    priority if (cmd.check && found) begin
      wr_en   = 1'b1;
      wr_addr = AW'(idx - FW'(1));
    end else if (cmd.finish && op_q == CMD_INSERT && ok_r) begin
      wr_en   = 1'b1;
      wr_addr = AW'(fill);
      wr_data = key_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[AW'(idx)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= cmd_t'(in_data[CMD_W-1:0]);
      key_q <= in_data[CMD_W +: SW];
      pos_q <= in_data[CMD_W+KEY_W +: POS_W];
    end
    if (cmd.start) begin
      idx   <= idx_start;
      found <= (op_q == CMD_REM_POS);
    end else if (cmd.check) begin
      idx   <= idx + FW'(1);
      found <= found | stat.hit;
    end
    if (cmd.finish) begin
      m_data <= {(OUT_W - 1 - KEY_W - CNT_W)'(0), fill_new_ext[CNT_W-1:0], kout_r, ok_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      m_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        fill    <= fill_new;
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = m_data;

endmodule

### src/bounded_unique_list_top.sv
// Top level of the bounded unique list: sequencer plus datapath.
// Depends on bul_pkg, bul_ctrl, bul_dpath and bounded_unique_list_top_assert.svh.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: cmd, key, position
//   m_*      out  m_tvalid/m_tready    m_tdata: ok, key_out, count
//
// Each item: accept, decide, scan, final step. Remove-by-key and a new insert scan all
// entries, an insert stops at its duplicate, remove-at-index scans those past the position,
// read scans one, all else none; each entry is read from registered memory, then compared.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// The next item is taken while the result waits in the output register; the block
// holds in its final step only while that register is still full.
`timescale 1ns / 1ps
`include "bounded_unique_list_top_assert.svh"

module bounded_unique_list_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [2:0] cmd, [34:3] key, [38:35] position, [39] zero
  input  logic [bul_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [0] ok, [32:1] key_out, [37:33] count, [39:38] zero
  output logic [bul_pkg::OUT_W-1:0]  m_tdata
);
  import bul_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_stat;

  // sequencer: one state per step of the scan
  bul_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // entry store, fill count, scan index, output register
  bul_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .in_data  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // one item at a time: busy right after an accept
  `BUL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // a result is only written into a free output slot
  `BUL_ASSERT_IMPL(a_finish_slot_free, dp_cmd.finish, dp_stat.out_free)
  // entries are only checked inside the live part of the list
  `BUL_ASSERT_IMPL(a_check_in_range, dp_cmd.check, !dp_stat.scan_end)

endmodule

### sim/bounded_unique_list_top_test.sv
// Self-checking testbench for bounded_unique_list_top: a directed pass over the corner
// cases, then random operation streams with idling and back-pressure on both streams.
// Depends on bul_pkg and the bounded_unique_list_top RTL.
`timescale 1ns / 1ps

module bounded_unique_list_top_test;
  import bul_pkg::*;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  // Slowest item is an insert scanning a full list; drain window is a bit above that.
  localparam int SLOWEST_ITEM = 2 * CAPACITY + 4;
  localparam int DRAIN_CYCLES = SLOWEST_ITEM + 8;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 300;

  // Command codes the block ignores.
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key_out;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Shadow copy of the list, updated when an item is accepted.
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  int               shadow_fill = 0;

  list_reply_t      reply_q[$];   // replies still owed by the block, oldest first
  int               fail_count  = 0;
  bit               steady_flow = 1'b0;  // no idling on either stream
  int               hold_left   = 0;     // receiver hold-off, counted down below
  list_reply_t      got_reply;
  list_reply_t      want_reply;

  bounded_unique_list_top #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected reply for one operation; applies the operation to the shadow list.
  function automatic list_reply_t apply_list_op(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
                                                logic [POS_W-1:0] pos);
    list_reply_t r;
    int          hit;
    int          drop;
    int          idx;
    r    = '0;
    hit  = -1;
    drop = -1;
    for (int i = 0; i < shadow_fill; i++)
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    case (op)
      CMD_INSERT: begin
        // duplicate or full list: refused, list unchanged
        if (hit < 0 && shadow_fill < CAPACITY) begin
          shadow_keys[shadow_fill] = k;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      CMD_REM_KEY: begin
        if (hit >= 0) drop = hit;
      end
      CMD_REM_POS: begin
        if (int'(pos) < shadow_fill) drop = pos;
      end
      CMD_READ: begin
        // position past the end reads the last entry
        if (shadow_fill > 0) begin
          idx       = (int'(pos) >= shadow_fill) ? shadow_fill - 1 : int'(pos);
          r.key_out = shadow_keys[idx];
          r.ok      = 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_fill = 0;
        r.ok        = 1'b1;
      end
      default: ;
    endcase
    if (drop >= 0) begin
      // compact: later entries move down one place
      shadow_fill--;
      for (int i = drop; i < shadow_fill; i++) shadow_keys[i] = shadow_keys[i + 1];
      r.ok = 1'b1;
    end
    r.count = shadow_fill[CNT_W-1:0];
    return r;
  endfunction

  // Offer one item from the falling edge on; returns once it is taken.
  task automatic send_item(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k, logic [POS_W-1:0] pos);
    @(negedge clk);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, k, op};  // [2:0] cmd, [34:3] key, [38:35] position
    do @(posedge clk); while (!s_tready);
    reply_q.push_back(apply_list_op(op, k, pos));
  endtask

  // Keys: mostly ones held now or from a small pool, so hits and duplicates are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (shadow_fill > 0 && r < 40) return shadow_keys[$urandom_range(shadow_fill - 1)];
    if (r < 70) return KEY_W'($urandom_range(23));
    return $urandom();
  endfunction

  task automatic send_random_item();
    int               r;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(99);
    if (r < 45)      op = CMD_INSERT;
    else if (r < 58) op = CMD_REM_KEY;
    else if (r < 70) op = CMD_REM_POS;
    else if (r < 94) op = CMD_READ;
    else if (r < 97) op = CMD_CLEAR;
    else             op = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    if (shadow_fill > 0 && $urandom_range(1)) pos = POS_W'($urandom_range(shadow_fill - 1));
    else pos = POS_W'($urandom_range(15));
    send_item(op, pick_key(), pos);
  endtask

  // Drop valid, then wait for every owed reply plus a safety margin.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_corner_ops();
    send_item(CMD_READ, 32'h0, 4'd15);               // read of an empty list
    send_item(CMD_REM_KEY, 32'h1234_5678, 4'd0);     // remove of an absent key
    send_item(CMD_REM_POS, 32'h0, 4'd0);             // remove-at-index past the end
    send_item(CMD_INSERT, 32'h0000_0000, 4'd0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);      // duplicate
    send_item(CMD_READ, 32'h0, 4'd15);               // clamped to the last entry
    send_item(CMD_REM_KEY, 32'h0000_0000, 4'd0);
    send_item(CMD_RSVD5, 32'hFFFF_FFFF, 4'd15);      // ignored code
    send_item(CMD_CLEAR, 32'h0, 4'd0);
    wait_drained();
  endtask

  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++) send_item(CMD_INSERT, 32'hA5A5_0000 + i, POS_W'(i));
    send_item(CMD_INSERT, 32'h5A5A_5A5A, 4'd0);      // refused: list full
    send_item(CMD_READ, 32'h0, 4'd15);
    send_item(CMD_REM_POS, 32'h0, 4'd0);             // longest compaction
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    repeat (n) send_random_item();
    wait_drained();
  endtask

  task automatic test_steady_flow(int n);
    steady_flow = 1'b1;
    repeat (n) send_random_item();
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // Receiver stops for a long stretch; the output register fills and input stalls.
  task automatic test_backpressure(int n);
    hold_left = HOLD_CYCLES;
    repeat (n) send_random_item();
    wait_drained();
  endtask

  // Receiver: random stalls, a counted hold-off on request, none in steady flow.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: each reply against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_reply.ok      = m_tdata[0];
      got_reply.key_out = m_tdata[32:1];
      got_reply.count   = m_tdata[37:33];
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply ok=%0b key_out=%h count=%0d", $time,
                 got_reply.ok, got_reply.key_out, got_reply.count);
        fail_count++;
      end else begin
        want_reply = reply_q.pop_front();
        if (got_reply.ok !== want_reply.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want_reply.ok, got_reply.ok);
          fail_count++;
        end
        if (got_reply.key_out !== want_reply.key_out) begin
          $display("%0t: key_out expected %h actual %h", $time,
                   want_reply.key_out, got_reply.key_out);
          fail_count++;
        end
        if (got_reply.count !== want_reply.count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   want_reply.count, got_reply.count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_ops();
    test_full_list();
    test_random_mix(200);
    test_steady_flow(80);
    test_backpressure(40);
    test_random_mix(80);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
